[sv/tlca_pkg.sv]
// tlca_pkg: shared widths, codes and controller states for the lca engine
// used by every module of the tree lca distance engine, no dependencies
package tlca_pkg;

   // field widths fixed by the interface
   localparam int NODE_W     = 10;
   localparam int LEN_W      = 16;
   localparam int OP_W       = 2;
   localparam int STAT_W     = 2;
   localparam int OUT_DIST_W = 26;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int DIST_W     = 32;

   // parameter defaults
   localparam int DEF_MAX_NODES   = 1024;
   localparam int DEF_LIFT_LEVELS = 10;
   localparam int DEF_MAX_EDGES   = 2048;

   localparam logic [DIST_W-1:0]     DIST_UNREACHED = '1;
   localparam logic [OUT_DIST_W-1:0] OUT_DIST_MAX   = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_UNREACHED = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROOT  = 1'd0,
      CSR_COUNT = 1'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FIN,
      ST_B_CLR, ST_B_ROOT, ST_B_QRD, ST_B_QCUR, ST_B_QDIST,
      ST_B_ERD, ST_B_ECHK, ST_B_EREL,
      ST_L_RD1, ST_L_RD2, ST_L_WR,
      ST_Q_START, ST_Q_RDB, ST_Q_CHK,
      ST_P1_RD, ST_P1_DEP, ST_P1_CMP, ST_P1_END,
      ST_P2_RX, ST_P2_RY, ST_P2_CMP, ST_P2_PAR, ST_P2_L,
      ST_Q_DL, ST_Q_DIST
   } state_type;

endpackage

[sv/tree_lca_distance_engine.sv]
// tree_lca_distance_engine: top level, request sequencer, visit queue, result register
// depends on tlca_pkg, tlca_edge_mem, tlca_node_mem, tlca_jump_mem
//
// Usage: requests arrive on req_* (valid/ready). Operation add stores one
// directed adjacency entry, build rebuilds distances, depths and the jump
// table from root_node, query returns the lowest common ancestor and the
// weighted path distance of two nodes. Every add, build and query gives one
// response on rsp_* (valid/ready); operation 3 is dropped with no response.
// csr_* writes root_node (index 0) and node_count (index 1); the user must
// do so only while idle, the block itself does not enforce it. A query
// walks a chain of dependent jump table and node memory reads, each a
// registered read. A build first sweeps MAX_NODES entries, then for
// every dequeued node reads every stored entry, then fills the jump table.
// One request is in work at a time; the next is accepted once the previous
// response sits in the output register, so a stalled receiver holds one
// response there, lets one more request run to completion, and then
// blocks further requests.
// Reset clears the control registers and the edge count; queries before
// the first build report node unreached.
module tree_lca_distance_engine #(
   parameter int MAX_NODES   = tlca_pkg::DEF_MAX_NODES,
   parameter int LIFT_LEVELS = tlca_pkg::DEF_LIFT_LEVELS,
   parameter int MAX_EDGES   = tlca_pkg::DEF_MAX_EDGES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tlca_pkg::OP_W-1:0]           req_operation,
   input  logic [tlca_pkg::NODE_W-1:0]         req_node_a,
   input  logic [tlca_pkg::NODE_W-1:0]         req_node_b,
   input  logic [tlca_pkg::LEN_W-1:0]          req_edge_length,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tlca_pkg::NODE_W-1:0]         rsp_ancestor_node,
   output logic [tlca_pkg::OUT_DIST_W-1:0]     rsp_path_distance,
   output logic [tlca_pkg::STAT_W-1:0]         rsp_status,
   input  logic                                csr_we,
   input  logic [tlca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tlca_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tlca_pkg::*;

   localparam int NW   = $clog2(MAX_NODES);
   localparam int NCW  = $clog2(MAX_NODES + 1);
   localparam int DEPW = NW + 1;
   localparam int EW   = $clog2(MAX_EDGES);
   localparam int ECW  = $clog2(MAX_EDGES + 1);
   localparam int LW   = LIFT_LEVELS > 1 ? $clog2(LIFT_LEVELS) : 1;
   localparam logic [LW-1:0]   LVL_TOP  = LW'(LIFT_LEVELS - 1);
   localparam logic [NW-1:0]   NODE_TOP = NW'(MAX_NODES - 1);
   localparam logic [DEPW-1:0] DEP_UNREACHED = '1;

   // control state
   state_type state_ff, state_in;
   logic [NODE_W-1:0]     root_ff;
   logic [CSR_DATA_W-1:0] count_ff;
   logic [ECW-1:0]        fill_ff;
   logic                  built_ff;
   logic                  ovf_ff;
   logic                  rsp_valid_ff;

   // datapath registers
   logic [NCW-1:0]        qn_ff, qi_ff;
   logic [NW-1:0]         v_ff, cur_ff, to_ff, x_ff, y_ff, up_ff, ux_ff, l_ff;
   logic [LW-1:0]         j_ff, i_ff;
   logic [ECW-1:0]        e_ff;
   logic [DIST_W-1:0]     curdist_ff, da_ff, db_ff;
   logic [DEPW-1:0]       curdep_ff, ha_ff, hx_ff;
   logic [LEN_W-1:0]      w_ff;
   logic [NODE_W-1:0]     qa_ff, qb_ff;
   logic [NODE_W-1:0]     anc_res_ff, rsp_anc_ff;
   logic [OUT_DIST_W-1:0] dist_res_ff, rsp_dist_ff;
   status_type            stat_res_ff, rsp_stat_ff;

   // memory ports
   logic              em_we;
   logic [EW-1:0]     em_raddr;
   logic [NODE_W-1:0] em_rsrc, em_rtgt;
   logic [LEN_W-1:0]  em_rlen;
   logic              nm_we;
   logic [NW-1:0]     nm_waddr, nm_raddr;
   logic [DIST_W-1:0] nm_wdist, nm_rdist;
   logic [DEPW-1:0]   nm_wdepth, nm_rdepth;
   logic              jm_we;
   logic [NW-1:0]     jm_wnode, jm_wdata, jm_rnode, jm_rdata;
   logic [LW-1:0]     jm_wlvl, jm_rlvl;
   logic              qm_we;
   logic [NW-1:0]     qm_waddr, qm_wdata, qm_rdata_ff;
   logic [NW-1:0]     qm_mem [MAX_NODES];

   // derived terms
   logic [NCW-1:0]    eff_n;
   logic              accept, edge_ok, relax, q_full, slot_free, root_bad, a_bad, b_bad;
   logic [DIST_W:0]   cand;
   logic [DIST_W-1:0] dl;
   logic signed [DIST_W+2:0] dsum;
   logic [OUT_DIST_W-1:0]    dclamp;

   // clamped node count
   always_comb begin
      if (count_ff == '0) begin
         eff_n = NCW'(1);
      end else if (32'(count_ff) > MAX_NODES) begin
         eff_n = NCW'(MAX_NODES);
      end else begin
         eff_n = NCW'(count_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign edge_ok   = (32'(em_rsrc) == 32'(cur_ff)) && (32'(em_rtgt) < 32'(eff_n));
   assign cand      = {1'b0, curdist_ff} + (DIST_W+1)'(w_ff);
   assign relax     = cand < {1'b0, nm_rdist};
   assign q_full    = 32'(qn_ff) >= MAX_NODES;
   assign root_bad  = 32'(root_ff) >= 32'(eff_n);
   assign a_bad     = 32'(qa_ff) >= 32'(eff_n);
   assign b_bad     = 32'(qb_ff) >= 32'(eff_n);

   // path distance with clamping
   always_comb begin
      dl   = (nm_rdist == DIST_UNREACHED) ? '0 : nm_rdist;
      dsum = $signed({3'b000, da_ff}) + $signed({3'b000, db_ff})
           - $signed({2'b00, dl, 1'b0});
      if (dsum < 0) begin
         dclamp = '0;
      end else if (dsum > $signed((DIST_W+3)'(OUT_DIST_MAX))) begin
         dclamp = OUT_DIST_MAX;
      end else begin
         dclamp = OUT_DIST_W'(dsum);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_ADD:   state_in = ST_FIN;
                  OP_BUILD: state_in = ST_B_CLR;
                  OP_QUERY: state_in = ST_Q_START;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIN:     if (slot_free) state_in = ST_IDLE;
         ST_B_CLR: begin
            if (v_ff == NODE_TOP) begin
               state_in = (ovf_ff || root_bad) ? ST_FIN : ST_B_ROOT;
            end
         end
         ST_B_ROOT:  state_in = ST_B_QRD;
         ST_B_QRD: begin
            if (qi_ff != qn_ff) begin
               state_in = ST_B_QCUR;
            end else begin
               state_in = (LIFT_LEVELS > 1) ? ST_L_RD1 : ST_FIN;
            end
         end
         ST_B_QCUR:  state_in = ST_B_QDIST;
         ST_B_QDIST: state_in = ST_B_ERD;
         ST_B_ERD:   state_in = (e_ff == fill_ff) ? ST_B_QRD : ST_B_ECHK;
         ST_B_ECHK:  state_in = edge_ok ? ST_B_EREL : ST_B_ERD;
         ST_B_EREL:  state_in = (relax && q_full) ? ST_B_CLR : ST_B_ERD;
         ST_L_RD1:   state_in = ST_L_RD2;
         ST_L_RD2:   state_in = ST_L_WR;
         ST_L_WR: begin
            state_in = (v_ff == NODE_TOP && j_ff == LVL_TOP) ? ST_FIN : ST_L_RD1;
         end
         ST_Q_START: state_in = (a_bad || b_bad || !built_ff) ? ST_FIN : ST_Q_RDB;
         ST_Q_RDB:   state_in = ST_Q_CHK;
         ST_Q_CHK: begin
            state_in = (da_ff == DIST_UNREACHED || nm_rdist == DIST_UNREACHED)
                     ? ST_FIN : ST_P1_RD;
         end
         ST_P1_RD:   state_in = ST_P1_DEP;
         ST_P1_DEP:  state_in = ST_P1_CMP;
         ST_P1_CMP:  state_in = (i_ff == '0) ? ST_P1_END : ST_P1_RD;
         ST_P1_END:  state_in = (x_ff == y_ff) ? ST_Q_DL : ST_P2_RX;
         ST_P2_RX:   state_in = ST_P2_RY;
         ST_P2_RY:   state_in = ST_P2_CMP;
         ST_P2_CMP:  state_in = (i_ff == '0) ? ST_P2_PAR : ST_P2_RX;
         ST_P2_PAR:  state_in = ST_P2_L;
         ST_P2_L:    state_in = ST_Q_DL;
         ST_Q_DL:    state_in = ST_Q_DIST;
         ST_Q_DIST:  state_in = ST_FIN;
         default:    state_in = ST_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      em_we     = 1'b0;
      em_raddr  = EW'(e_ff);
      nm_we     = 1'b0;
      nm_waddr  = v_ff;
      nm_wdist  = DIST_UNREACHED;
      nm_wdepth = DEP_UNREACHED;
      nm_raddr  = cur_ff;
      jm_we     = 1'b0;
      jm_wnode  = v_ff;
      jm_wlvl   = '0;
      jm_wdata  = v_ff;
      jm_rnode  = v_ff;
      jm_rlvl   = j_ff - LW'(1);
      qm_we     = 1'b0;
      qm_waddr  = NW'(qn_ff);
      qm_wdata  = to_ff;
      case (state_ff)
         ST_IDLE: begin
            em_we = accept && (op_type'(req_operation) == OP_ADD)
                  && (32'(fill_ff) < MAX_EDGES);
         end
         ST_B_CLR: begin
            nm_we = 1'b1;
            jm_we = 1'b1;
         end
         ST_B_ROOT: begin
            nm_we     = 1'b1;
            nm_waddr  = NW'(root_ff);
            nm_wdist  = '0;
            nm_wdepth = '0;
            qm_we     = 1'b1;
            qm_waddr  = '0;
            qm_wdata  = NW'(root_ff);
         end
         ST_B_QCUR:  nm_raddr = qm_rdata_ff;
         ST_B_ECHK:  nm_raddr = NW'(em_rtgt);
         ST_B_EREL: begin
            if (relax && !q_full) begin
               nm_we     = 1'b1;
               nm_waddr  = to_ff;
               nm_wdist  = cand[DIST_W-1:0];
               nm_wdepth = curdep_ff + DEPW'(1);
               jm_we     = 1'b1;
               jm_wnode  = to_ff;
               jm_wdata  = cur_ff;
               qm_we     = 1'b1;
            end
         end
         ST_L_RD2:   jm_rnode = jm_rdata;
         ST_L_WR: begin
            jm_we    = 1'b1;
            jm_wlvl  = j_ff;
            jm_wdata = jm_rdata;
         end
         ST_Q_START: nm_raddr = NW'(qa_ff);
         ST_Q_RDB:   nm_raddr = NW'(qb_ff);
         ST_P1_RD: begin
            jm_rnode = y_ff;
            jm_rlvl  = i_ff;
         end
         ST_P1_DEP:  nm_raddr = jm_rdata;
         ST_P2_RX: begin
            jm_rnode = x_ff;
            jm_rlvl  = i_ff;
         end
         ST_P2_RY: begin
            jm_rnode = y_ff;
            jm_rlvl  = i_ff;
         end
         ST_P2_PAR: begin
            jm_rnode = x_ff;
            jm_rlvl  = '0;
         end
         ST_Q_DL:    nm_raddr = l_ff;
         default: begin
         end
      endcase
   end

   // visit queue memory
   always_ff @(posedge clock) begin
      if (qm_we) begin
         qm_mem[qm_waddr] <= qm_wdata;
      end
      qm_rdata_ff <= qm_mem[NW'(qi_ff)];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         root_ff      <= '0;
         count_ff     <= CSR_DATA_W'(1);
         fill_ff      <= '0;
         built_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ROOT:  root_ff  <= NODE_W'(csr_wdata);
               CSR_COUNT: count_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (em_we) begin
            fill_ff <= fill_ff + ECW'(1);
         end
         if (accept && op_type'(req_operation) == OP_BUILD) begin
            ovf_ff <= 1'b0;
         end
         if (state_ff == ST_B_EREL && relax && q_full) begin
            ovf_ff <= 1'b1;
         end
         if (state_ff == ST_B_CLR && v_ff == NODE_TOP) begin
            built_ff <= 1'b1;
         end
         if (state_ff == ST_FIN && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && slot_free) begin
         rsp_anc_ff  <= anc_res_ff;
         rsp_dist_ff <= dist_res_ff;
         rsp_stat_ff <= stat_res_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            anc_res_ff  <= '0;
            dist_res_ff <= '0;
            v_ff        <= '0;
            qa_ff       <= req_node_a;
            qb_ff       <= req_node_b;
            // a full edge store only affects an add
            if (op_type'(req_operation) == OP_ADD && 32'(fill_ff) >= MAX_EDGES) begin
               stat_res_ff <= STAT_FULL;
            end else begin
               stat_res_ff <= STAT_OK;
            end
         end
         ST_B_CLR: begin
            v_ff <= v_ff + NW'(1);
            if (v_ff == NODE_TOP) begin
               if (ovf_ff) begin
                  stat_res_ff <= STAT_OVERFLOW;
               end else if (root_bad) begin
                  stat_res_ff <= STAT_UNREACHED;
               end
            end
         end
         ST_B_ROOT: begin
            qn_ff <= NCW'(1);
            qi_ff <= '0;
            j_ff  <= LW'(1);
            v_ff  <= '0;
         end
         ST_B_QCUR:  cur_ff <= qm_rdata_ff;
         ST_B_QDIST: begin
            curdist_ff <= nm_rdist;
            curdep_ff  <= nm_rdepth;
            e_ff       <= '0;
            qi_ff      <= qi_ff + NCW'(1);
         end
         ST_B_ECHK: begin
            to_ff <= NW'(em_rtgt);
            w_ff  <= em_rlen;
            if (!edge_ok) begin
               e_ff <= e_ff + ECW'(1);
            end
         end
         ST_B_EREL: begin
            e_ff <= e_ff + ECW'(1);
            if (relax && q_full) begin
               v_ff <= '0;
            end else if (relax) begin
               qn_ff <= qn_ff + NCW'(1);
            end
         end
         ST_L_WR: begin
            v_ff <= v_ff + NW'(1);
            if (v_ff == NODE_TOP) begin
               j_ff <= j_ff + LW'(1);
            end
         end
         ST_Q_START: begin
            if (a_bad || b_bad || !built_ff) begin
               stat_res_ff <= STAT_UNREACHED;
            end
         end
         ST_Q_RDB: begin
            da_ff <= nm_rdist;
            ha_ff <= nm_rdepth;
         end
         ST_Q_CHK: begin
            db_ff <= nm_rdist;
            i_ff  <= LVL_TOP;
            if (da_ff == DIST_UNREACHED || nm_rdist == DIST_UNREACHED) begin
               stat_res_ff <= STAT_UNREACHED;
            end
            if (ha_ff > nm_rdepth) begin
               x_ff  <= NW'(qb_ff);
               y_ff  <= NW'(qa_ff);
               hx_ff <= nm_rdepth;
            end else begin
               x_ff  <= NW'(qa_ff);
               y_ff  <= NW'(qb_ff);
               hx_ff <= ha_ff;
            end
         end
         ST_P1_DEP:  up_ff <= jm_rdata;
         ST_P1_CMP: begin
            if (nm_rdepth >= hx_ff) begin
               y_ff <= up_ff;
            end
            i_ff <= i_ff - LW'(1);
         end
         ST_P1_END: begin
            l_ff <= x_ff;
            i_ff <= LVL_TOP;
         end
         ST_P2_RY:   ux_ff <= jm_rdata;
         ST_P2_CMP: begin
            if (ux_ff != jm_rdata) begin
               x_ff <= ux_ff;
               y_ff <= jm_rdata;
            end
            i_ff <= i_ff - LW'(1);
         end
         ST_P2_L:    l_ff <= jm_rdata;
         ST_Q_DIST: begin
            anc_res_ff  <= NODE_W'(l_ff);
            dist_res_ff <= dclamp;
         end
         default: begin
         end
      endcase
   end

   tlca_edge_mem #(.MAX_EDGES(MAX_EDGES)) u_edge (
      .clock (clock),
      .we    (em_we),
      .waddr (EW'(fill_ff)),
      .wsrc  (req_node_a),
      .wtgt  (req_node_b),
      .wlen  (req_edge_length),
      .raddr (em_raddr),
      .rsrc  (em_rsrc),
      .rtgt  (em_rtgt),
      .rlen  (em_rlen)
   );

   tlca_node_mem #(.MAX_NODES(MAX_NODES)) u_node (
      .clock  (clock),
      .we     (nm_we),
      .waddr  (nm_waddr),
      .wdist  (nm_wdist),
      .wdepth (nm_wdepth),
      .raddr  (nm_raddr),
      .rdist  (nm_rdist),
      .rdepth (nm_rdepth)
   );

   tlca_jump_mem #(.MAX_NODES(MAX_NODES), .LIFT_LEVELS(LIFT_LEVELS)) u_jump (
      .clock (clock),
      .we    (jm_we),
      .wnode (jm_wnode),
      .wlvl  (jm_wlvl),
      .wdata (jm_wdata),
      .rnode (jm_rnode),
      .rlvl  (jm_rlvl),
      .rdata (jm_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ancestor_node = rsp_anc_ff;
   assign rsp_path_distance = rsp_dist_ff;
   assign rsp_status        = rsp_stat_ff;

   // queue never grows past its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_ERD) |-> (32'(qn_ff) <= MAX_NODES && qi_ff <= qn_ff))
      else $error("visit queue count out of range");

   // edge store count never exceeds its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_EDGES)
      else $error("edge fill count out of range");

   // an accepted add, build or query blocks further requests next cycle
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (accept && op_type'(req_operation) != OP_NONE) |=> !req_ready)
      else $error("request accepted while another is in work");

   // a waiting response is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_stat_ff)))
      else $error("pending response lost");

endmodule

[sv/tlca_edge_mem.sv]
// tlca_edge_mem: adjacency entry store, source, target and weight per entry
// uses tlca_pkg for field widths
module tlca_edge_mem #(
   parameter int MAX_EDGES = tlca_pkg::DEF_MAX_EDGES
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(MAX_EDGES)-1:0]   waddr,
   input  logic [tlca_pkg::NODE_W-1:0]    wsrc,
   input  logic [tlca_pkg::NODE_W-1:0]    wtgt,
   input  logic [tlca_pkg::LEN_W-1:0]     wlen,
   input  logic [$clog2(MAX_EDGES)-1:0]   raddr,
   output logic [tlca_pkg::NODE_W-1:0]    rsrc,
   output logic [tlca_pkg::NODE_W-1:0]    rtgt,
   output logic [tlca_pkg::LEN_W-1:0]     rlen
);
   import tlca_pkg::*;

   localparam int EWID = 2 * NODE_W + LEN_W;

   logic [EWID-1:0] mem [MAX_EDGES];
   logic [EWID-1:0] rdata_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= {wsrc, wtgt, wlen};
      end
      rdata_ff <= mem[raddr];
   end

   assign {rsrc, rtgt, rlen} = rdata_ff;

endmodule

[sv/tlca_node_mem.sv]
// tlca_node_mem: per-node weighted distance and hop depth
// uses tlca_pkg for the distance width
module tlca_node_mem #(
   parameter int MAX_NODES = tlca_pkg::DEF_MAX_NODES
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(MAX_NODES)-1:0]   waddr,
   input  logic [tlca_pkg::DIST_W-1:0]    wdist,
   input  logic [$clog2(MAX_NODES):0]     wdepth,
   input  logic [$clog2(MAX_NODES)-1:0]   raddr,
   output logic [tlca_pkg::DIST_W-1:0]    rdist,
   output logic [$clog2(MAX_NODES):0]     rdepth
);
   import tlca_pkg::*;

   localparam int DEPW = $clog2(MAX_NODES) + 1;

   logic [DIST_W+DEPW-1:0] mem [MAX_NODES];
   logic [DIST_W+DEPW-1:0] rdata_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= {wdist, wdepth};
      end
      rdata_ff <= mem[raddr];
   end

   assign {rdist, rdepth} = rdata_ff;

endmodule

[sv/tlca_jump_mem.sv]
// tlca_jump_mem: binary lifting table, one ancestor per node and level
// uses tlca_pkg for parameter defaults
module tlca_jump_mem #(
   parameter int MAX_NODES   = tlca_pkg::DEF_MAX_NODES,
   parameter int LIFT_LEVELS = tlca_pkg::DEF_LIFT_LEVELS
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [$clog2(MAX_NODES)-1:0]                wnode,
   input  logic [(LIFT_LEVELS > 1 ? $clog2(LIFT_LEVELS) : 1)-1:0] wlvl,
   input  logic [$clog2(MAX_NODES)-1:0]                wdata,
   input  logic [$clog2(MAX_NODES)-1:0]                rnode,
   input  logic [(LIFT_LEVELS > 1 ? $clog2(LIFT_LEVELS) : 1)-1:0] rlvl,
   output logic [$clog2(MAX_NODES)-1:0]                rdata
);
   import tlca_pkg::*;

   localparam int NW = $clog2(MAX_NODES);

   logic [NW-1:0] mem [MAX_NODES][LIFT_LEVELS];
   logic [NW-1:0] rdata_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wnode][wlvl] <= wdata;
      end
      rdata_ff <= mem[rnode][rlvl];
   end

   assign rdata = rdata_ff;

endmodule
